/* hdl/mstd_pkg.sv */
`default_nettype none
package mstd_pkg;

	localparam int RATE_ENTRIES = 6;
	localparam int RESULT_LIMIT = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REG,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		STATUS_FIRED  = 2'd0,
		STATUS_ACCEPT = 2'd1,
		STATUS_REJECT = 2'd2
	} status_t;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_REG  = 1'b1;

	typedef struct packed {
		logic [7:0] tick;
		logic [1:0] extra;
		logic [2:0] entry;
	} slot_t;

	typedef struct packed {
		slot_t nxt;
		logic  expire;
	} step_t;

	function automatic logic [7:0] rate_reload(input logic [2:0] entry);
		logic [7:0] r;
		case (entry)
			3'd1: r = 8'd1;
			3'd2: r = 8'd10;
			3'd3: r = 8'd8;
			3'd4: r = 8'd5;
			3'd5: r = 8'd250;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] rate_extra(input logic [2:0] entry);
		logic [1:0] r;
		case (entry)
			3'd3: r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/mstd_slot_step.sv */
`default_nettype none
module mstd_slot_step (
	input  mstd_pkg::slot_t cur,
	output mstd_pkg::step_t step
);

	logic [7:0] t1;
	logic [1:0] e1;
	logic [7:0] reload;

	always_comb begin
		t1 = cur.tick - 8'd1;
		e1 = cur.extra - 2'd1;
		reload = mstd_pkg::rate_reload(cur.entry);
		step.nxt = cur;
		step.expire = 1'b0;
		if (cur.tick != 8'd0) begin
			step.nxt.tick = t1;
			if (t1 == 8'd0) begin
				step.expire = 1'b1;
				step.nxt.tick = reload;
				if (cur.extra != 2'd0) begin
					step.nxt.extra = e1;
					if (e1 == 2'd0) begin
						step.nxt.tick = reload + 8'd1;
						step.nxt.extra = mstd_pkg::rate_extra(cur.entry);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/multi_slot_fractional_tick_divider_core.sv */
// Multi-slot tick divider: EVENT_SLOTS event slots driven from a base tick.
// Input channel (in_valid/in_ready) carries command, slot and freq_index.
// A tick item (command 0) walks the slots one per cycle while the output
// does not stall, decrementing each active counter; every slot that expires
// yields one result item with status fired, up to RESULT_LIMIT per tick, and
// the final one of the tick carries last. A tick holds in_ready low through
// its walk and flush, also while the receiver stalls, and a tick with no
// expiry gives no result. A register item (command 1) loads one slot from
// the rate table and yields a single accepted or rejected result, which the
// ST_REG state loads into the output register. The block takes one item at
// a time; in_ready is high only between items. The slot walk through the
// shared step unit sets the tick rate. Results go through one output
// register; while the receiver holds out_ready low, the walk pauses at the
// next reported expiry and the result waits unchanged. Reset clears all
// slots except slots 2 and 3, which start on rate entry 1, and drops any
// pending result.
`default_nettype none
module multi_slot_fractional_tick_divider_core #(
	parameter int EVENT_SLOTS = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        command,
	input  wire [3:0]  slot,
	input  wire [2:0]  freq_index,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [3:0] event_slot,
	output logic [1:0] status,
	output logic       last
);

	localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	mstd_pkg::state_t state_q, state_d;

	logic [7:0]       tick_q  [EVENT_SLOTS];
	logic [1:0]       extra_q [EVENT_SLOTS];
	logic [2:0]       entry_q [EVENT_SLOTS];

	logic [IDX_W-1:0] idx_q;
	logic [3:0]       n_q;
	logic             pend_valid_q;
	logic [3:0]       pend_slot_q;
	logic [3:0]       reg_slot_q;
	logic [2:0]       reg_idx_q;

	mstd_pkg::slot_t  cur;
	mstd_pkg::step_t  step;

	logic             out_free;
	logic             last_idx;
	logic             report;
	logic             stall;
	logic             scan_go;
	logic             reg_ok;
	logic             reg_go;
	logic             out_load;
	logic [3:0]       out_slot_d;
	logic [1:0]       out_status_d;
	logic             out_last_d;

	assign cur.tick  = tick_q[idx_q];
	assign cur.extra = extra_q[idx_q];
	assign cur.entry = entry_q[idx_q];

	mstd_slot_step u_step (
		.cur  (cur),
		.step (step)
	);

	assign out_free = !out_valid || out_ready;
	assign last_idx = (idx_q == IDX_W'(EVENT_SLOTS - 1));
	assign reg_ok   = ({1'b0, reg_slot_q} < 5'(EVENT_SLOTS))
		&& ({1'b0, reg_idx_q} < 4'(mstd_pkg::RATE_ENTRIES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			mstd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (command == mstd_pkg::CMD_REG) ? mstd_pkg::ST_REG
						: mstd_pkg::ST_SCAN;
				end
			end
			mstd_pkg::ST_REG: begin
				if (out_free) state_d = mstd_pkg::ST_IDLE;
			end
			mstd_pkg::ST_SCAN: begin
				if (!stall && last_idx) state_d = mstd_pkg::ST_FLUSH;
			end
			mstd_pkg::ST_FLUSH: begin
				if (!pend_valid_q || out_free) state_d = mstd_pkg::ST_IDLE;
			end
			default: state_d = mstd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == mstd_pkg::ST_IDLE);
		report       = step.expire && (n_q < 4'(mstd_pkg::RESULT_LIMIT));
		stall        = 1'b0;
		scan_go      = 1'b0;
		reg_go       = 1'b0;
		out_load     = 1'b0;
		out_slot_d   = pend_slot_q;
		out_status_d = mstd_pkg::STATUS_FIRED;
		out_last_d   = 1'b0;
		case (state_q)
			mstd_pkg::ST_REG: begin
				reg_go       = out_free;
				out_load     = out_free;
				out_slot_d   = reg_slot_q;
				out_status_d = reg_ok ? mstd_pkg::STATUS_ACCEPT : mstd_pkg::STATUS_REJECT;
				out_last_d   = 1'b1;
			end
			mstd_pkg::ST_SCAN: begin
				stall    = report && pend_valid_q && !out_free;
				scan_go  = !stall;
				out_load = !stall && report && pend_valid_q;
			end
			mstd_pkg::ST_FLUSH: begin
				out_load   = pend_valid_q && out_free;
				out_last_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mstd_pkg::ST_IDLE;
			idx_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
			for (int i = 0; i < EVENT_SLOTS; i++) begin
				tick_q[i]  <= (i == 2 || i == 3) ? 8'd1 : 8'd0;
				extra_q[i] <= 2'd0;
				entry_q[i] <= (i == 2 || i == 3) ? 3'd1 : 3'd0;
			end
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				idx_q <= '0;
				n_q   <= '0;
			end
			if (scan_go) begin
				tick_q[idx_q]  <= step.nxt.tick;
				extra_q[idx_q] <= step.nxt.extra;
				entry_q[idx_q] <= step.nxt.entry;
				if (!last_idx) idx_q <= idx_q + IDX_W'(1);
				if (report) begin
					pend_valid_q <= 1'b1;
					n_q          <= n_q + 4'd1;
				end
			end
			if (state_q == mstd_pkg::ST_FLUSH && out_load) pend_valid_q <= 1'b0;
			if (reg_go && reg_ok) begin
				tick_q[reg_slot_q[IDX_W-1:0]]  <= mstd_pkg::rate_reload(reg_idx_q);
				extra_q[reg_slot_q[IDX_W-1:0]] <= mstd_pkg::rate_extra(reg_idx_q);
				entry_q[reg_slot_q[IDX_W-1:0]] <= reg_idx_q;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			reg_slot_q <= slot;
			reg_idx_q  <= freq_index;
		end
		if (scan_go && report) pend_slot_q <= 4'(idx_q);
		if (out_load) begin
			event_slot <= out_slot_d;
			status     <= out_status_d;
			last       <= out_last_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/mstd_checker.sv */
`default_nettype none
module mstd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [3:0] event_slot,
	input wire [1:0] status,
	input wire       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_slot)
			&& $stable(status) && $stable(last))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready while an item is in work");

	a_reg_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mstd_pkg::STATUS_ACCEPT
			|| status == mstd_pkg::STATUS_REJECT) |-> last)
		else $error("register result without last");

	a_nonfinal_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready && status == mstd_pkg::STATUS_FIRED)
		else $error("non-final result outside a tick walk");

endmodule

bind multi_slot_fractional_tick_divider_core mstd_checker u_mstd_checker (.*);
`default_nettype wire
